FILE: sv/rau_pkg.sv
// ============================================================================
// rau_pkg - shared types and constants for the rational arithmetic unit
// Operation codes, field widths, sequencer states and the request/response
// structs between the front sequencer and the GCD reduction engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int NUM_W     = 16;
    localparam int DEN_W     = 15;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;
    localparam int OP_W      = 17;                  // multiplier operand, signed
    localparam int PROD_W    = 2 * OP_W;            // full product width
    localparam int MAG_W     = 31;                  // magnitudes in the reducer
    localparam int CNT_W     = 5;                   // step and shift counters

    // Last step of a restoring division (one quotient bit per step)
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 2'd3;

    // Front sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_START,
        ST_REDUCE,
        ST_OUT
    } top_state_t;

    // Reduction engine states
    typedef enum logic [2:0] {
        RD_IDLE,
        RD_TWOS,
        RD_LOOP,
        RD_DIVN,
        RD_DIVD
    } red_state_t;

    // Request from the front sequencer; mag and den hold while busy
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] den;
    } red_req_t;

    // Response from the reduction engine
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quo_num;
        logic [MAG_W-1:0] quo_den;
    } red_rsp_t;

endpackage

`default_nettype wire

FILE: sv/rau_mult.sv
// ============================================================================
// rau_mult - shared signed multiplier
// One 17x17 signed multiply per cycle with a registered product; the
// sequencer issues the cross products through it one after another.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rau_mult (
    input  wire logic                                   aclk,
    input  wire logic signed [rau_pkg::OP_W-1:0]        op_a,
    input  wire logic signed [rau_pkg::OP_W-1:0]        op_b,
    output logic signed      [rau_pkg::PROD_W-1:0]      prod
);

    logic signed [rau_pkg::PROD_W-1:0] prod_reg;
    logic signed [rau_pkg::PROD_W-1:0] prod_next;

    // Form the full product
    always_comb begin
        prod_next = op_a * op_b;
    end

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/rau_reduce.sv
// ============================================================================
// rau_reduce - GCD reduction engine
// Binary GCD of numerator magnitude and denominator, then two restoring
// divisions by the GCD, all through one shared 33-bit subtractor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rau_reduce (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rau_pkg::red_req_t   req,
    output rau_pkg::red_rsp_t        rsp
);

    localparam int MW = rau_pkg::MAG_W;
    localparam int CW = rau_pkg::CNT_W;

    rau_pkg::red_state_t state_reg, state_next;

    logic [MW-1:0] x_reg,       x_next;
    logic [MW-1:0] y_reg,       y_next;
    logic [CW-1:0] k_reg,       k_next;
    logic [MW-1:0] g_reg,       g_next;
    logic [MW-1:0] rem_reg,     rem_next;
    logic [MW-1:0] dq_reg,      dq_next;
    logic [CW-1:0] cnt_reg,     cnt_next;
    logic [MW-1:0] quo_num_reg, quo_num_next;
    logic [MW-1:0] quo_den_reg, quo_den_next;
    logic          done_reg,    done_next;

    // Shared subtractor
    logic [MW:0]   trial;
    logic [MW:0]   sub_a;
    logic [MW:0]   sub_b;
    logic [MW+1:0] diff;
    logic          borrow;
    logic [MW-1:0] qword;

    // Select subtractor operands: GCD compare or division trial
    always_comb begin
        trial = {rem_reg, dq_reg[MW-1]};
        if (state_reg == rau_pkg::RD_LOOP) begin
            sub_a = {1'b0, x_reg};
            sub_b = {1'b0, y_reg};
        end else begin
            sub_a = trial;
            sub_b = {1'b0, g_reg};
        end
        diff   = {1'b0, sub_a} - {1'b0, sub_b};
        borrow = diff[MW+1];
        qword  = {dq_reg[MW-2:0], ~borrow};
    end

    // Sequence the GCD and the two divisions
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        cnt_next     = cnt_reg;
        quo_num_next = quo_num_reg;
        quo_den_next = quo_den_reg;
        done_next    = 1'b0;

        case (state_reg)
            rau_pkg::RD_IDLE: begin
                if (req.start) begin
                    x_next     = req.mag;
                    y_next     = req.den;
                    k_next     = '0;
                    state_next = rau_pkg::RD_TWOS;
                end
            end
            rau_pkg::RD_TWOS: begin
                // Strip common factors of two
                if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CW'(1);
                end else begin
                    state_next = rau_pkg::RD_LOOP;
                end
            end
            rau_pkg::RD_LOOP: begin
                if (x_reg == '0) begin
                    // GCD is the odd part times the common power of two
                    g_next     = y_reg << k_reg;
                    rem_next   = '0;
                    dq_next    = req.mag;
                    cnt_next   = '0;
                    state_next = rau_pkg::RD_DIVN;
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (borrow) begin
                    // Keep x the larger of the two odd values
                    x_next = y_reg;
                    y_next = x_reg;
                end else begin
                    x_next = {1'b0, diff[MW-1:1]};
                end
            end
            rau_pkg::RD_DIVN, rau_pkg::RD_DIVD: begin
                // One quotient bit per step
                rem_next = borrow ? trial[MW-1:0] : diff[MW-1:0];
                dq_next  = qword;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == rau_pkg::DIV_LAST) begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == rau_pkg::RD_DIVN) begin
                        quo_num_next = qword;
                        dq_next      = req.den;
                        state_next   = rau_pkg::RD_DIVD;
                    end else begin
                        quo_den_next = qword;
                        done_next    = 1'b1;
                        state_next   = rau_pkg::RD_IDLE;
                    end
                end
            end
            default: begin
                state_next = rau_pkg::RD_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::RD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        cnt_reg     <= cnt_next;
        quo_num_reg <= quo_num_next;
        quo_den_reg <= quo_den_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.quo_num = quo_num_reg;
    assign rsp.quo_den = quo_den_reg;

endmodule

`default_nettype wire

FILE: sv/rational_arithmetic_unit.sv
// ============================================================================
// rational_arithmetic_unit - fraction add, subtract, multiply and divide
// Cross-multiplies two fractions and reduces the result by its GCD.
// ============================================================================
// Usage:
//   Slave channel: s_tuser carries the operation, s_tdata the two fractions.
//   Master channel: m_tdata carries the reduced numerator and the positive
//   denominator, m_tuser flags a divide by a zero fraction (the first
//   operand then comes back unreduced). A reduced zero result is given as 0/1.
//   One transaction in gives exactly one transaction out.
//   Timing: s_tready is high only while the unit is idle. A transaction
//   runs its cross products on the shared multiplier, then the binary
//   GCD on the shared subtractor (one step per cycle, as many steps as
//   the operands need), then two 31-step divisions by the GCD.
//   A divide by a zero fraction skips all of that and goes straight to output.
//   The result waits in an output register; a new transaction is accepted
//   while it waits, but the next result holds in the sequencer until the
//   receiver takes the previous one.
//   Reset: synchronous, active low; clears the sequencers and m_tvalid.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // a_num[15:0], a_den[30:16], b_num[46:31],
                                        // b_den[61:47], zero pad [63:62]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    // Result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // res_num[31:0], res_den[62:32], zero pad [63]
    output logic             m_tuser    // div_zero[0]
);

    localparam int MW = rau_pkg::MAG_W;
    localparam int RN = rau_pkg::RES_NUM_W;
    localparam int RD = rau_pkg::RES_DEN_W;

    rau_pkg::top_state_t state_reg, state_next;

    // Captured operands
    logic [rau_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic signed [rau_pkg::NUM_W-1:0] an_reg,   an_next;
    logic [rau_pkg::DEN_W-1:0]        ad_reg,   ad_next;
    logic signed [rau_pkg::NUM_W-1:0] bn_reg,   bn_next;
    logic [rau_pkg::DEN_W-1:0]        bd_reg,   bd_next;

    // Working result
    logic signed [RN-1:0] num_reg,     num_next;
    logic [RD-1:0]        den_reg,     den_next;
    logic signed [RN-1:0] res_num_reg, res_num_next;
    logic [RD-1:0]        res_den_reg, res_den_next;
    logic                 dz_reg,      dz_next;

    // Output register
    logic                 m_valid_reg,   m_valid_next;
    logic [RN-1:0]        m_num_reg,     m_num_next;
    logic [RD-1:0]        m_den_reg,     m_den_next;
    logic                 m_dz_reg,      m_dz_next;

    // Multiplier operands
    logic signed [rau_pkg::OP_W-1:0]   op_a;
    logic signed [rau_pkg::OP_W-1:0]   op_b;
    logic signed [rau_pkg::PROD_W-1:0] prod;
    logic signed [rau_pkg::OP_W-1:0]   an17, ad17, bn17, bd17, an_div, bn_abs;

    // Input fields
    logic signed [rau_pkg::NUM_W-1:0] s_an, s_bn;
    logic [rau_pkg::DEN_W-1:0]        s_ad, s_bd, s_ad_fix, s_bd_fix;

    // Reducer handoff
    rau_pkg::red_req_t red_req;
    rau_pkg::red_rsp_t red_rsp;
    logic [RN-1:0]     mag_full;
    logic [RN-1:0]     quo32;

    assign s_an     = s_tdata[15:0];
    assign s_ad     = s_tdata[30:16];
    assign s_bn     = s_tdata[46:31];
    assign s_bd     = s_tdata[61:47];
    // Treat a zero denominator as one
    assign s_ad_fix = (s_ad == '0) ? rau_pkg::DEN_W'(1) : s_ad;
    assign s_bd_fix = (s_bd == '0) ? rau_pkg::DEN_W'(1) : s_bd;

    // Select cross-product operands per step
    always_comb begin
        an17   = {an_reg[rau_pkg::NUM_W-1], an_reg};
        bn17   = {bn_reg[rau_pkg::NUM_W-1], bn_reg};
        ad17   = {2'b00, ad_reg};
        bd17   = {2'b00, bd_reg};
        // Move the divisor sign to the numerator
        an_div = bn_reg[rau_pkg::NUM_W-1] ? -an17 : an17;
        bn_abs = bn_reg[rau_pkg::NUM_W-1] ? -bn17 : bn17;
        op_a   = '0;
        op_b   = '0;
        case (state_reg)
            rau_pkg::ST_MUL0: begin
                if (mode_reg == rau_pkg::MODE_MUL) begin
                    op_a = an17;
                    op_b = bn17;
                end else if (mode_reg == rau_pkg::MODE_DIV) begin
                    op_a = an_div;
                    op_b = bd17;
                end else begin
                    op_a = an17;
                    op_b = bd17;
                end
            end
            rau_pkg::ST_MUL1: begin
                op_a = ad17;
                op_b = bn17;
            end
            rau_pkg::ST_MUL2: begin
                op_a = ad17;
                op_b = (mode_reg == rau_pkg::MODE_DIV) ? bn_abs : bd17;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    rau_mult u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Magnitude handoff to the reducer; the sign stays in num_reg
    assign mag_full      = num_reg[RN-1] ? (RN'(0) - num_reg) : num_reg;
    assign red_req.mag   = mag_full[MW-1:0];
    assign red_req.den   = den_reg;
    assign red_req.start = (state_reg == rau_pkg::ST_START);
    assign quo32         = {1'b0, red_rsp.quo_num};

    rau_reduce u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (red_req),
        .rsp     (red_rsp)
    );

    // Sequence one transaction
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        dz_next      = dz_reg;
        m_valid_next = m_valid_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_dz_next    = m_dz_reg;

        // Drop the output once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next = s_tuser;
                    an_next   = s_an;
                    ad_next   = s_ad_fix;
                    bn_next   = s_bn;
                    bd_next   = s_bd_fix;
                    if (s_tuser == rau_pkg::MODE_DIV && s_bn == '0) begin
                        // Divide by a zero fraction: pass the first operand
                        res_num_next = {{(RN - rau_pkg::NUM_W){s_an[rau_pkg::NUM_W-1]}}, s_an};
                        res_den_next = {{(RD - rau_pkg::DEN_W){1'b0}}, s_ad_fix};
                        dz_next      = 1'b1;
                        state_next   = rau_pkg::ST_OUT;
                    end else begin
                        dz_next    = 1'b0;
                        state_next = rau_pkg::ST_MUL0;
                    end
                end
            end
            rau_pkg::ST_MUL0: begin
                state_next = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                num_next   = prod[RN-1:0];
                state_next = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                if (mode_reg == rau_pkg::MODE_ADD) begin
                    num_next = num_reg + prod[RN-1:0];
                end else if (mode_reg == rau_pkg::MODE_SUB) begin
                    num_next = num_reg - prod[RN-1:0];
                end
                state_next = rau_pkg::ST_MUL3;
            end
            rau_pkg::ST_MUL3: begin
                den_next   = prod[RD-1:0];
                state_next = rau_pkg::ST_START;
            end
            rau_pkg::ST_START: begin
                state_next = rau_pkg::ST_REDUCE;
            end
            rau_pkg::ST_REDUCE: begin
                if (red_rsp.done) begin
                    res_num_next = num_reg[RN-1] ? (RN'(0) - quo32) : quo32;
                    res_den_next = red_rsp.quo_den;
                    state_next   = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_num_next   = res_num_reg;
                    m_den_next   = res_den_reg;
                    m_dz_next    = dz_reg;
                    state_next   = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        dz_reg      <= dz_next;
        m_num_reg   <= m_num_next;
        m_den_reg   <= m_den_next;
        m_dz_reg    <= m_dz_next;
    end

    assign s_tready = (state_reg == rau_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_den_reg, m_num_reg};
    assign m_tuser  = m_dz_reg;

endmodule

`default_nettype wire

FILE: sv/rau_checker.sv
// ============================================================================
// rau_checker - port-level checks for the rational arithmetic unit
// Watches the handshakes and the result encoding on the top-level ports.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rau_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    // Stay busy right after accepting a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Denominator is never zero
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[62:32] != 31'd0)
        else $error("zero denominator in result");

    // Reduced zero result reads 0/1
    a_zero_is_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[31:0] == 32'd0 |-> m_tdata[62:32] == 31'd1)
        else $error("zero result not reduced to 0/1");

    // Clear the result channel at reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/rational_arithmetic_unit_tb.sv
// ============================================================================
// rational_arithmetic_unit_tb - self-checking bench for the fraction unit
// Sends fraction pairs with all four operations, first a directed set of
// corner cases, then random pairs under four idling patterns and one long
// receiver hold-off. Each result is checked field by field against an
// in-bench GCD reduction of the same operation.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit_tb;

    localparam int QUIET_LIMIT = 20000;    // cycles with no transaction at all
    localparam int HOLD_CYCLES = 800;      // long receiver hold-off
    localparam int PHASE_OPS   = 160;      // random operations per idling phase (ten more in the first)

    typedef struct packed {
        logic [rau_pkg::MODE_W-1:0] mode;
        logic [rau_pkg::NUM_W-1:0]  a_num;
        logic [rau_pkg::DEN_W-1:0]  a_den;
        logic [rau_pkg::NUM_W-1:0]  b_num;
        logic [rau_pkg::DEN_W-1:0]  b_den;
    } fraction_op_t;

    typedef struct packed {
        logic [rau_pkg::RES_NUM_W-1:0] res_num;
        logic [rau_pkg::RES_DEN_W-1:0] res_den;
        logic                          div_zero;
    } fraction_res_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    fraction_op_t  queued_operations[$];
    fraction_res_t expected_reductions[$];
    fraction_op_t  driven_op = '0;
    logic          op_taken  = 1'b0;
    logic          hold_off  = 1'b0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            accepted_ops   = 0;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;

    rational_arithmetic_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Compute the reduced fraction for one operation
    function automatic fraction_res_t reduce_fraction(fraction_op_t op);
        longint an, ad, bn, bd, num, den, x, y, t;
        fraction_res_t r;
        an = longint'($signed(op.a_num));
        bn = longint'($signed(op.b_num));
        ad = (op.a_den == '0) ? 64'sd1 : longint'(op.a_den);
        bd = (op.b_den == '0) ? 64'sd1 : longint'(op.b_den);
        // Division by a zero fraction returns the first operand unreduced
        if (op.mode == rau_pkg::MODE_DIV && bn == 0) begin
            r.res_num  = an[rau_pkg::RES_NUM_W-1:0];
            r.res_den  = ad[rau_pkg::RES_DEN_W-1:0];
            r.div_zero = 1'b1;
            return r;
        end
        case (op.mode)
            rau_pkg::MODE_ADD: begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            rau_pkg::MODE_SUB: begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            rau_pkg::MODE_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
                // Move the divisor's sign onto the numerator
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
            end
        endcase
        // Euclid on the magnitudes
        x = (num < 0) ? -num : num;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0) x = 1;
        num = num / x;
        den = den / x;
        r.res_num  = num[rau_pkg::RES_NUM_W-1:0];
        r.res_den  = den[rau_pkg::RES_DEN_W-1:0];
        r.div_zero = 1'b0;
        return r;
    endfunction

    // Numerator drawn from full range, small values, extremes or factor multiples
    function automatic logic [rau_pkg::NUM_W-1:0] random_numerator(int factor);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return rau_pkg::NUM_W'($urandom);
        if (pick < 70) return rau_pkg::NUM_W'(int'($urandom_range(40)) - 20);
        if (pick < 80) begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                3: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return rau_pkg::NUM_W'(factor * (int'($urandom_range(1000)) - 500));
    endfunction

    // Denominator, including the out-of-range zero now and then
    function automatic logic [rau_pkg::DEN_W-1:0] random_denominator(int factor);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)  return '0;
        if (pick < 38) return rau_pkg::DEN_W'($urandom_range(32767, 1));
        if (pick < 73) return rau_pkg::DEN_W'($urandom_range(30, 1));
        if (pick < 88) return rau_pkg::DEN_W'(factor * int'($urandom_range(500, 1)));
        return ($urandom_range(1) == 0) ? rau_pkg::DEN_W'(1) : rau_pkg::DEN_W'(32767);
    endfunction

    function automatic fraction_op_t random_fraction_op();
        fraction_op_t op;
        int factor;
        factor   = int'($urandom_range(60, 2));
        op.mode  = rau_pkg::MODE_W'($urandom_range(3));
        op.a_num = random_numerator(factor);
        op.a_den = random_denominator(factor);
        op.b_num = random_numerator(factor);
        op.b_den = random_denominator(factor);
        if (op.mode == rau_pkg::MODE_DIV && $urandom_range(9) == 0) op.b_num = '0;
        return op;
    endfunction

    task automatic queue_op(logic [rau_pkg::MODE_W-1:0] mode, int an, int ad, int bn, int bd);
        fraction_op_t op;
        op.mode  = mode;
        op.a_num = rau_pkg::NUM_W'(an);
        op.a_den = rau_pkg::DEN_W'(ad);
        op.b_num = rau_pkg::NUM_W'(bn);
        op.b_den = rau_pkg::DEN_W'(bd);
        queued_operations.push_back(op);
    endtask

    task automatic drain_queue();
        while (queued_operations.size() != 0) @(posedge aclk);
    endtask

    // Clock and reset
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Input driver: present the next operation once the current one is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || op_taken)) begin
            if (queued_operations.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                driven_op <= queued_operations[0];
                s_tdata   <= {2'b00, queued_operations[0].b_den, queued_operations[0].b_num,
                              queued_operations[0].a_den, queued_operations[0].a_num};
                s_tuser   <= queued_operations[0].mode;
                s_tvalid  <= 1'b1;
                void'(queued_operations.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus the long hold-off
    always @(negedge aclk) begin
        m_tready <= aresetn && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: record accepted operations, check results, watch for a hang
    always @(posedge aclk) begin
        fraction_res_t got, want;
        if (aresetn) begin
            op_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_reductions.push_back(reduce_fraction(driven_op));
                accepted_ops++;
            end
            if (m_tvalid && m_tready) begin
                got.res_num  = m_tdata[31:0];
                got.res_den  = m_tdata[62:32];
                got.div_zero = m_tuser;
                if (expected_reductions.size() == 0) begin
                    $display("%0t: unexpected result %0d/%0d div_zero=%0b", $time,
                             $signed(got.res_num), got.res_den, got.div_zero);
                    mismatch_count++;
                end else begin
                    want = expected_reductions.pop_front();
                    if (got.res_num !== want.res_num) begin
                        $display("%0t: res_num expected %0d, got %0d", $time,
                                 $signed(want.res_num), $signed(got.res_num));
                        mismatch_count++;
                    end
                    if (got.res_den !== want.res_den) begin
                        $display("%0t: res_den expected %0d, got %0d", $time,
                                 want.res_den, got.res_den);
                        mismatch_count++;
                    end
                    if (got.div_zero !== want.div_zero) begin
                        $display("%0t: div_zero expected %0b, got %0b", $time,
                                 want.div_zero, got.div_zero);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Hold off the receiver so the unit fills up and stalls its input
    initial begin
        wait (accepted_ops >= 40);
        @(negedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    // Stimulus
    initial begin
        wait (aresetn);

        // Basic operations and zero result
        queue_op(rau_pkg::MODE_ADD, 1, 2, 1, 3);
        queue_op(rau_pkg::MODE_SUB, 1, 2, 1, 2);
        queue_op(rau_pkg::MODE_MUL, -3, 4, 2, 3);
        queue_op(rau_pkg::MODE_DIV, 1, 2, 3, 4);
        queue_op(rau_pkg::MODE_ADD, 5, 1, -7, 1);
        queue_op(rau_pkg::MODE_MUL, 0, 7, 5, 3);
        // Divide by a zero fraction: first operand unreduced
        queue_op(rau_pkg::MODE_DIV, 7, 14, 0, 5);
        queue_op(rau_pkg::MODE_DIV, -32768, 32767, 0, 1);
        queue_op(rau_pkg::MODE_DIV, 0, 0, 0, 0);
        // Divide by a negative fraction
        queue_op(rau_pkg::MODE_DIV, 1, 3, -2, 5);
        queue_op(rau_pkg::MODE_DIV, -32768, 1, -32768, 32767);
        queue_op(rau_pkg::MODE_DIV, -6, 35, -4, 21);
        queue_op(rau_pkg::MODE_DIV, 32767, 32767, -1, 32767);
        // Field extremes
        queue_op(rau_pkg::MODE_ADD, -32768, 32767, -32768, 32767);
        queue_op(rau_pkg::MODE_ADD, 32767, 32767, 32767, 32767);
        queue_op(rau_pkg::MODE_SUB, -32768, 1, 32767, 1);
        queue_op(rau_pkg::MODE_SUB, 32767, 32766, -32768, 32767);
        queue_op(rau_pkg::MODE_MUL, -32768, 1, -32768, 1);
        queue_op(rau_pkg::MODE_MUL, 32767, 32767, 32767, 32767);
        // Zero denominators act as one
        queue_op(rau_pkg::MODE_ADD, 5, 0, 1, 2);
        queue_op(rau_pkg::MODE_MUL, 3, 4, 2, 0);
        queue_op(rau_pkg::MODE_DIV, 6, 0, 4, 0);

        // Random phases: no idling, sender idle, receiver stalling, both
        repeat (PHASE_OPS + 10) queued_operations.push_back(random_fraction_op());
        drain_queue();
        send_idle_pct = 80;
        repeat (PHASE_OPS) queued_operations.push_back(random_fraction_op());
        drain_queue();
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        repeat (PHASE_OPS) queued_operations.push_back(random_fraction_op());
        drain_queue();
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        repeat (PHASE_OPS) queued_operations.push_back(random_fraction_op());
        drain_queue();

        // Let everything drain, then allow a stray late result to show up
        while (s_tvalid || expected_reductions.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
